FILE: rtl/ddmo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddmo_pkg: shared types and constants
// State and operation codes, fixed-point angle constants, CORDIC arctangent
// table and saturation helper for the wheel mixer and odometry block.
// ----------------------------------------------------------------------------
package ddmo_pkg;

	// control sequencer
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_POST,
		ST_ROUND,
		ST_HEAD,
		ST_FOLD,
		ST_CORDIC,
		ST_CEND,
		ST_OUT
	} state_t;

	// products taken through the shared serial multiplier, in order
	typedef enum logic [3:0] {
		OP_FWD,
		OP_TURN,
		OP_PL,
		OP_PR,
		OP_DPHI,
		OP_X,
		OP_Y,
		OP_FS,
		OP_TR
	} op_t;

	// configuration register index
	typedef enum logic [1:0] {
		CFG_VELOCITY_GAIN    = 2'd0,
		CFG_MM_PER_COUNT     = 2'd1,
		CFG_RADIANS_PER_MM   = 2'd2,
		CFG_TICKS_PER_SECOND = 2'd3
	} cfg_index_t;

	localparam logic [15:0] GAIN_RST = 16'd1715;
	localparam logic [23:0] MMPC_RST = 24'd29244;
	localparam logic [23:0] RPMM_RST = 24'd46603;
	localparam logic [9:0]  TPS_RST  = 10'd100;

	// Q4.28 angles, Q2.30 CORDIC start value
	localparam logic signed [33:0] TWO_PI    = 34'sd1686629713;
	localparam logic signed [33:0] PI        = 34'sd843314857;
	localparam logic signed [33:0] HALF_PI   = 34'sd421657428;
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

	// arctan(2^-i) in Q2.30
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:    r = 32'd843314856;
			5'd1:    r = 32'd497837829;
			5'd2:    r = 32'd263043836;
			5'd3:    r = 32'd133525158;
			5'd4:    r = 32'd67021686;
			5'd5:    r = 32'd33543515;
			5'd6:    r = 32'd16775850;
			5'd7:    r = 32'd8388437;
			5'd8:    r = 32'd4194282;
			5'd9:    r = 32'd2097149;
			5'd10:   r = 32'd1048575;
			default: r = 32'h4000_0000 >> i;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		priority if (v > 68'sd2147483647) begin
			r = 32'sh7fff_ffff;
		end else if (v < -68'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/diff_drive_mix_and_odometry.sv
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_mix_and_odometry: wheel mixer and wheel odometry
// Per control tick: motor demands from the velocity commands, and pose,
// distance and speed estimates from the two encoder positions.
// ----------------------------------------------------------------------------
// Usage
//   s_* : one word per control tick; tdata carries cmd_linear, cmd_angular,
//         left_position and right_position (32 bits each, lowest first).
//   m_* : one result word per tick: both motor demands, pose, distance and
//         speeds packed into 304 bits (see port list).
//   cfg_*: register write, taken at any edge with cfg_we high; write only
//         while no tick is in flight.
// Timing
//   Works one tick at a time. All products go through one shift-and-add
//   multiplier, one bit of the multiplier operand per cycle, and the sine
//   and cosine through a CORDIC doing one rotation per cycle.
//   The result sits in an output register: s_tready returns as soon as the
//   result is written there, so the next tick runs while the receiver
//   stalls; that tick then waits at its end until the register is free.
// Reset
//   Clears pose, heading, travel and previous encoder positions to zero and
//   loads the register defaults; no result is pending after reset.
// ----------------------------------------------------------------------------
module diff_drive_mix_and_odometry #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// cmd_linear, cmd_angular, left_position, right_position
	input  wire logic [127:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// left_demand, right_demand, pose_x, pose_y, pose_heading,
	// distance_total, forward_speed, turn_rate
	output logic [303:0]      m_tdata,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_addr,
	input  wire logic [23:0]  cfg_wdata
);

	localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	ddmo_pkg::state_t state_q, state_d;
	ddmo_pkg::op_t    op_q, op_d;

	// configuration
	logic [15:0] gain_q;
	logic [23:0] mmpc_q;
	logic [23:0] rpmm_q;
	logic [9:0]  tps_q;

	// odometry state
	logic signed [31:0] prev_l_q, prev_r_q;
	logic signed [31:0] heading_q;
	logic signed [47:0] pos_x_q, pos_y_q, travel_q;

	// per-tick working registers
	logic signed [31:0] lin_q, ang_q;
	logic signed [32:0] dl_q, dr_q;
	logic signed [32:0] fwd_q;
	logic signed [31:0] left_d_q, right_d_q;
	logic signed [56:0] pl_q;
	logic signed [57:0] sum_q, dif_q;
	logic signed [31:0] step_q, diff_q, dphi_q;
	logic signed [31:0] fspeed_q, trate_q;

	// serial multiplier
	logic signed [67:0] acc_q, a_q;
	logic signed [33:0] b_q;
	logic [5:0]         cnt_q;
	logic signed [67:0] ld_a, ld_bias;
	logic signed [33:0] ld_b;
	logic [5:0]         ld_nb;

	// CORDIC
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic signed [33:0] cos_q, sin_q;
	logic               neg_q;
	logic [IW-1:0]      it_q;

	logic               out_load;
	logic [303:0]       out_q;
	logic               mvalid_q;

	// input unpack, left count negated
	logic signed [31:0] in_lin, in_ang, in_nl, in_nr;
	assign in_lin = s_tdata[31:0];
	assign in_ang = s_tdata[63:32];
	assign in_nl  = 32'd0 - s_tdata[95:64];
	assign in_nr  = s_tdata[127:96];

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddmo_pkg::ST_IDLE;
			op_q    <= ddmo_pkg::OP_FWD;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ddmo_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ddmo_pkg::ST_LOAD;
					op_d    = ddmo_pkg::OP_FWD;
				end
			end
			ddmo_pkg::ST_LOAD: state_d = ddmo_pkg::ST_MUL;
			ddmo_pkg::ST_MUL: begin
				if (cnt_q == 6'd1) state_d = ddmo_pkg::ST_POST;
			end
			ddmo_pkg::ST_POST: begin
				unique case (op_q)
					ddmo_pkg::OP_FWD: begin
						state_d = ddmo_pkg::ST_LOAD;
						op_d    = ddmo_pkg::OP_TURN;
					end
					ddmo_pkg::OP_TURN: begin
						state_d = ddmo_pkg::ST_LOAD;
						op_d    = ddmo_pkg::OP_PL;
					end
					ddmo_pkg::OP_PL: begin
						state_d = ddmo_pkg::ST_LOAD;
						op_d    = ddmo_pkg::OP_PR;
					end
					ddmo_pkg::OP_PR:   state_d = ddmo_pkg::ST_ROUND;
					ddmo_pkg::OP_DPHI: state_d = ddmo_pkg::ST_HEAD;
					ddmo_pkg::OP_X: begin
						state_d = ddmo_pkg::ST_LOAD;
						op_d    = ddmo_pkg::OP_Y;
					end
					ddmo_pkg::OP_Y: begin
						state_d = ddmo_pkg::ST_LOAD;
						op_d    = ddmo_pkg::OP_FS;
					end
					ddmo_pkg::OP_FS: begin
						state_d = ddmo_pkg::ST_LOAD;
						op_d    = ddmo_pkg::OP_TR;
					end
					ddmo_pkg::OP_TR: state_d = ddmo_pkg::ST_OUT;
					default:         state_d = ddmo_pkg::ST_IDLE;
				endcase
			end
			ddmo_pkg::ST_ROUND: begin
				state_d = ddmo_pkg::ST_LOAD;
				op_d    = ddmo_pkg::OP_DPHI;
			end
			ddmo_pkg::ST_HEAD: state_d = ddmo_pkg::ST_FOLD;
			ddmo_pkg::ST_FOLD: state_d = ddmo_pkg::ST_CORDIC;
			ddmo_pkg::ST_CORDIC: begin
				if (it_q == IW'(CORDIC_STEPS - 1)) state_d = ddmo_pkg::ST_CEND;
			end
			ddmo_pkg::ST_CEND: begin
				state_d = ddmo_pkg::ST_LOAD;
				op_d    = ddmo_pkg::OP_X;
			end
			ddmo_pkg::ST_OUT: begin
				if (!mvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ddmo_pkg::ST_IDLE;
				end
			end
			default: state_d = ddmo_pkg::ST_IDLE;
		endcase
	end

	// ---------------- multiplier operand select ----------------
	// The accumulator starts at the rounding bias: its sign term is known
	// from the operand signs, and a zero product still rounds to zero.
	always_comb begin
		ld_a    = 68'sd0;
		ld_b    = 34'sd0;
		ld_nb   = 6'd1;
		ld_bias = 68'sd0;
		unique case (op_q)
			ddmo_pkg::OP_FWD: begin
				ld_a    = 68'(lin_q);
				ld_b    = 34'(gain_q);
				ld_nb   = 6'd17;
				ld_bias = lin_q[31] ? 68'sd65535 : 68'sd0;
			end
			ddmo_pkg::OP_TURN: begin
				ld_a    = 68'(ang_q);
				ld_b    = 34'(gain_q);
				ld_nb   = 6'd17;
				ld_bias = ang_q[31] ? 68'sd65535 : 68'sd0;
			end
			ddmo_pkg::OP_PL: begin
				ld_a  = 68'(dl_q);
				ld_b  = 34'(mmpc_q);
				ld_nb = 6'd25;
			end
			ddmo_pkg::OP_PR: begin
				ld_a  = 68'(dr_q);
				ld_b  = 34'(mmpc_q);
				ld_nb = 6'd25;
			end
			ddmo_pkg::OP_DPHI: begin
				ld_a    = 68'(diff_q);
				ld_b    = 34'(rpmm_q);
				ld_nb   = 6'd25;
				ld_bias = diff_q[31] ? 68'sd2047 : 68'sd2048;
			end
			ddmo_pkg::OP_X: begin
				ld_a    = 68'(step_q);
				ld_b    = cos_q;
				ld_nb   = 6'd34;
				ld_bias = (step_q[31] ^ cos_q[33]) ? 68'sd536870911 : 68'sd536870912;
			end
			ddmo_pkg::OP_Y: begin
				ld_a    = 68'(step_q);
				ld_b    = sin_q;
				ld_nb   = 6'd34;
				ld_bias = (step_q[31] ^ sin_q[33]) ? 68'sd536870911 : 68'sd536870912;
			end
			ddmo_pkg::OP_FS: begin
				ld_a  = 68'(step_q);
				ld_b  = 34'(tps_q);
				ld_nb = 6'd11;
			end
			ddmo_pkg::OP_TR: begin
				ld_a    = 68'(dphi_q);
				ld_b    = 34'(tps_q);
				ld_nb   = 6'd11;
				ld_bias = dphi_q[31] ? 68'sd2047 : 68'sd2048;
			end
			default: ;
		endcase
	end

	// ---------------- post-product arithmetic ----------------
	logic signed [32:0] turn_v;
	logic signed [33:0] mix_l, mix_r;
	logic signed [67:0] sh12;
	logic signed [57:0] pr_v;
	logic signed [57:0] r_step, r_diff;
	logic signed [33:0] h0, h1, h2;
	logic signed [33:0] f0, f1, f2;
	logic signed [33:0] sy, sx;
	logic [31:0]        at;

	always_comb begin
		turn_v = 33'(acc_q >>> 16);
		mix_l  = 34'(turn_v) - 34'(fwd_q);
		mix_r  = 34'(fwd_q) + 34'(turn_v);
		sh12   = acc_q >>> 12;
		pr_v   = 58'(signed'(acc_q[56:0]));

		// rounding to nearest, ties away from zero
		r_step = (sum_q + (sum_q[57] ? 58'sd255 : 58'sd256)) >>> 9;
		r_diff = (dif_q + (dif_q[57] ? 58'sd127 : 58'sd128)) >>> 8;

		// heading wrap by 2*pi
		h0 = 34'(heading_q) + 34'(dphi_q);
		h1 = (h0 >= ddmo_pkg::TWO_PI) ? h0 - ddmo_pkg::TWO_PI : h0;
		h2 = (h1 <= -ddmo_pkg::TWO_PI) ? h1 + ddmo_pkg::TWO_PI : h1;

		// fold heading into (-pi, pi]
		f0 = 34'(heading_q);
		f1 = (f0 > ddmo_pkg::PI) ? f0 - ddmo_pkg::TWO_PI : f0;
		f2 = (f1 <= -ddmo_pkg::PI) ? f1 + ddmo_pkg::TWO_PI : f1;

		sy = cy_q >>> it_q;
		sx = cx_q >>> it_q;
		at = ddmo_pkg::atan_q30(5'(it_q));
	end

	// ---------------- state and control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= ddmo_pkg::GAIN_RST;
			mmpc_q    <= ddmo_pkg::MMPC_RST;
			rpmm_q    <= ddmo_pkg::RPMM_RST;
			tps_q     <= ddmo_pkg::TPS_RST;
			prev_l_q  <= '0;
			prev_r_q  <= '0;
			heading_q <= '0;
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			travel_q  <= '0;
			mvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (ddmo_pkg::cfg_index_t'(cfg_addr))
					ddmo_pkg::CFG_VELOCITY_GAIN:    gain_q <= cfg_wdata[15:0];
					ddmo_pkg::CFG_MM_PER_COUNT:     mmpc_q <= cfg_wdata;
					ddmo_pkg::CFG_RADIANS_PER_MM:   rpmm_q <= cfg_wdata;
					ddmo_pkg::CFG_TICKS_PER_SECOND: tps_q  <= cfg_wdata[9:0];
					default: ;
				endcase
			end
			if (state_q == ddmo_pkg::ST_IDLE && s_tvalid) begin
				prev_l_q <= in_nl;
				prev_r_q <= in_nr;
			end
			if (state_q == ddmo_pkg::ST_HEAD) begin
				heading_q <= h2[31:0];
			end
			if (state_q == ddmo_pkg::ST_POST) begin
				unique case (op_q)
					ddmo_pkg::OP_X:  pos_x_q  <= pos_x_q + 48'(acc_q >>> 30);
					ddmo_pkg::OP_Y:  pos_y_q  <= pos_y_q + 48'(acc_q >>> 30);
					ddmo_pkg::OP_FS: travel_q <= travel_q + 48'(step_q);
					default: ;
				endcase
			end
			if (out_load) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ddmo_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					lin_q <= in_lin;
					ang_q <= in_ang;
					dl_q  <= 33'(in_nl) - 33'(prev_l_q);
					dr_q  <= 33'(in_nr) - 33'(prev_r_q);
				end
			end
			ddmo_pkg::ST_LOAD: begin
				acc_q <= ld_bias;
				a_q   <= ld_a;
				b_q   <= ld_b;
				cnt_q <= ld_nb;
			end
			ddmo_pkg::ST_MUL: begin
				// last bit is the operand's sign bit: its weight is negative
				if (b_q[0]) begin
					acc_q <= (cnt_q == 6'd1) ? acc_q - a_q : acc_q + a_q;
				end
				a_q   <= a_q <<< 1;
				b_q   <= b_q >>> 1;
				cnt_q <= cnt_q - 6'd1;
			end
			ddmo_pkg::ST_POST: begin
				unique case (op_q)
					ddmo_pkg::OP_FWD: fwd_q <= turn_v;
					ddmo_pkg::OP_TURN: begin
						left_d_q  <= ddmo_pkg::sat32(68'(mix_l));
						right_d_q <= ddmo_pkg::sat32(68'(mix_r));
					end
					ddmo_pkg::OP_PL: pl_q <= acc_q[56:0];
					ddmo_pkg::OP_PR: begin
						sum_q <= pr_v + 58'(pl_q);
						dif_q <= pr_v - 58'(pl_q);
					end
					ddmo_pkg::OP_DPHI: begin
						priority if (sh12 > 68'(ddmo_pkg::TWO_PI)) begin
							dphi_q <= ddmo_pkg::TWO_PI[31:0];
						end else if (sh12 < -68'(ddmo_pkg::TWO_PI)) begin
							dphi_q <= 32'(-ddmo_pkg::TWO_PI);
						end else begin
							dphi_q <= sh12[31:0];
						end
					end
					ddmo_pkg::OP_FS: fspeed_q <= ddmo_pkg::sat32(acc_q);
					ddmo_pkg::OP_TR: trate_q  <= ddmo_pkg::sat32(sh12);
					default: ;
				endcase
			end
			ddmo_pkg::ST_ROUND: begin
				step_q <= ddmo_pkg::sat32(68'(r_step));
				diff_q <= ddmo_pkg::sat32(68'(r_diff));
			end
			ddmo_pkg::ST_FOLD: begin
				cx_q <= ddmo_pkg::CORDIC_X0;
				cy_q <= '0;
				it_q <= '0;
				priority if (f2 > ddmo_pkg::HALF_PI) begin
					cz_q  <= (f2 - ddmo_pkg::PI) <<< 2;
					neg_q <= 1'b1;
				end else if (f2 < -ddmo_pkg::HALF_PI) begin
					cz_q  <= (f2 + ddmo_pkg::PI) <<< 2;
					neg_q <= 1'b1;
				end else begin
					cz_q  <= f2 <<< 2;
					neg_q <= 1'b0;
				end
			end
			ddmo_pkg::ST_CORDIC: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - sy;
					cy_q <= cy_q + sx;
					cz_q <= cz_q - 34'(at);
				end else begin
					cx_q <= cx_q + sy;
					cy_q <= cy_q - sx;
					cz_q <= cz_q + 34'(at);
				end
				it_q <= it_q + IW'(1);
			end
			ddmo_pkg::ST_CEND: begin
				cos_q <= neg_q ? -cx_q : cx_q;
				sin_q <= neg_q ? -cy_q : cy_q;
			end
			ddmo_pkg::ST_OUT: begin
				if (out_load) begin
					out_q <= {trate_q, fspeed_q, travel_q, heading_q,
					          pos_y_q, pos_x_q, right_d_q, left_d_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = out_q;

endmodule
`default_nettype wire
